>>> src/jdc_pkg.sv
// Shared types, character codes, phase codes and error codes for the
// descriptor checker. No dependencies.
package jdc_pkg;

  localparam int OFFSET_BITS_DEF = 16;

  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_PSTART = 4'd1;
  localparam logic [3:0] PH_PDIMS  = 4'd2;
  localparam logic [3:0] PH_PNAME  = 4'd3;
  localparam logic [3:0] PH_RSTART = 4'd4;
  localparam logic [3:0] PH_RDIMS  = 4'd5;
  localparam logic [3:0] PH_RNAME  = 4'd6;
  localparam logic [3:0] PH_FDIMS  = 4'd7;
  localparam logic [3:0] PH_FNAME  = 4'd8;
  localparam logic [3:0] PH_DONE   = 4'd9;
  localparam logic [3:0] PH_ERR    = 4'd10;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_EMPTY      = 4'd1;
  localparam logic [3:0] ERR_NO_PAREN   = 4'd2;
  localparam logic [3:0] ERR_DEPTH      = 4'd3;
  localparam logic [3:0] ERR_TRUNC      = 4'd4;
  localparam logic [3:0] ERR_NO_SEMI    = 4'd5;
  localparam logic [3:0] ERR_NAME       = 4'd6;
  localparam logic [3:0] ERR_MARKER     = 4'd7;
  localparam logic [3:0] ERR_VOID       = 4'd8;
  localparam logic [3:0] ERR_F_TRAIL    = 4'd9;
  localparam logic [3:0] ERR_SLOTS      = 4'd10;
  localparam logic [3:0] ERR_NO_CLOSE   = 4'd11;
  localparam logic [3:0] ERR_NO_RESULT  = 4'd12;
  localparam logic [3:0] ERR_M_TRAIL    = 4'd13;
  localparam logic [3:0] ERR_TOO_LONG   = 4'd14;

  localparam logic [3:0] KIND_Z   = 4'd0;
  localparam logic [3:0] KIND_B   = 4'd1;
  localparam logic [3:0] KIND_C   = 4'd2;
  localparam logic [3:0] KIND_S   = 4'd3;
  localparam logic [3:0] KIND_I   = 4'd4;
  localparam logic [3:0] KIND_J   = 4'd5;
  localparam logic [3:0] KIND_F   = 4'd6;
  localparam logic [3:0] KIND_D   = 4'd7;
  localparam logic [3:0] KIND_V   = 4'd8;
  localparam logic [3:0] KIND_OBJ = 4'd9;

  localparam logic [1:0] ROLE_FIELD  = 2'd0;
  localparam logic [1:0] ROLE_PARAM  = 2'd1;
  localparam logic [1:0] ROLE_RESULT = 2'd2;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam logic [7:0] DIM_MAX  = 8'd255;

  typedef struct packed {
    logic [3:0] phase;
    logic       method_mode;
    logic [7:0] dim_count;
    logic       nf_bad;
    logic       nf_slash;
    logic       nf_chars;
    logic [7:0] slot_sum;
    logic [7:0] param_count;
    logic [3:0] err_code;
  } state_t;

  typedef struct packed {
    logic       rtype;
    logic [1:0] role;
    logic [3:0] kind;
    logic [7:0] dims;
    logic [1:0] slots;
    logic [7:0] idx;
    logic [7:0] tot;
    logic [3:0] ecode;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_START, method_mode: 1'b0, dim_count: 8'd0, nf_bad: 1'b0,
    nf_slash: 1'b0, nf_chars: 1'b0, slot_sum: 8'd0, param_count: 8'd0,
    err_code: ERR_NONE
  };

  // Returns {valid, kind} for a base type letter.
  function automatic logic [4:0] base_kind(input logic [7:0] b);
    logic [4:0] r;
    case (b)
      8'h5A:   r = {1'b1, KIND_Z};
      8'h42:   r = {1'b1, KIND_B};
      8'h43:   r = {1'b1, KIND_C};
      8'h53:   r = {1'b1, KIND_S};
      8'h49:   r = {1'b1, KIND_I};
      8'h4A:   r = {1'b1, KIND_J};
      8'h46:   r = {1'b1, KIND_F};
      8'h44:   r = {1'b1, KIND_D};
      8'h56:   r = {1'b1, KIND_V};
      default: r = {1'b0, KIND_Z};
    endcase
    return r;
  endfunction

endpackage

>>> src/jdc_step.sv
// Next-state and result logic for one descriptor request.
// Depends on jdc_pkg.
module jdc_step #(
  parameter int OffsetBits = jdc_pkg::OFFSET_BITS_DEF
) (
  input  jdc_pkg::state_t         st,
  input  logic [OffsetBits-1:0]   byte_offset,
  input  logic [OffsetBits-1:0]   type_start,
  input  logic [OffsetBits-1:0]   name_start,
  input  logic [OffsetBits-1:0]   err_offset,
  input  logic                    req_type,
  input  logic [7:0]              data_byte,
  input  logic                    is_method,
  output jdc_pkg::state_t         st_next,
  output logic [OffsetBits-1:0]   byte_offset_next,
  output logic [OffsetBits-1:0]   type_start_next,
  output logic [OffsetBits-1:0]   name_start_next,
  output logic [OffsetBits-1:0]   err_offset_next,
  output logic                    res_valid,
  output jdc_pkg::result_t        res,
  output logic [OffsetBits-1:0]   res_err_offset
);
  import jdc_pkg::*;

  localparam logic [OffsetBits-1:0] OffMax = '1;

  always_comb begin
    logic                  mm;
    logic                  lat;
    logic [3:0]            lcode;
    logic [OffsetBits-1:0] loff;
    logic [3:0]            wph;
    logic [7:0]            wdim;
    logic [OffsetBits-1:0] wts;
    logic [OffsetBits-1:0] wns;
    logic                  dims_p;
    logic                  name_p;
    logic                  do_cmp;
    logic [3:0]            kind;
    logic [4:0]            bk;
    logic [1:0]            slots;
    logic [8:0]            sum;
    logic                  in_res;

    mm     = (st.phase == PH_START) ? is_method : st.method_mode;
    lat    = 1'b0;
    lcode  = ERR_NONE;
    loff   = '0;
    wph    = st.phase;
    wdim   = st.dim_count;
    wts    = type_start;
    wns    = name_start;
    dims_p = 1'b0;
    name_p = 1'b0;
    do_cmp = 1'b0;
    kind   = 4'd0;
    bk     = 5'd0;
    slots  = 2'd0;
    sum    = 9'd0;
    in_res = 1'b0;

    st_next          = st;
    st_next.method_mode = mm;
    byte_offset_next = byte_offset;
    type_start_next  = type_start;
    name_start_next  = name_start;
    err_offset_next  = err_offset;
    res_valid        = 1'b0;
    res              = '0;
    res_err_offset   = '0;

    if (req_type) begin
      case (st.phase)
        PH_START: begin
          lat = 1'b1; lcode = mm ? ERR_NO_PAREN : ERR_EMPTY; loff = '0;
        end
        PH_PSTART: begin
          lat = 1'b1; lcode = ERR_NO_CLOSE; loff = byte_offset;
        end
        PH_RSTART: begin
          lat = 1'b1; lcode = ERR_NO_RESULT; loff = byte_offset;
        end
        PH_PDIMS, PH_RDIMS, PH_FDIMS: begin
          lat = 1'b1; lcode = ERR_TRUNC; loff = byte_offset;
        end
        PH_PNAME, PH_RNAME, PH_FNAME: begin
          lat = 1'b1; lcode = ERR_NO_SEMI; loff = name_start;
        end
        default: lat = 1'b0;
      endcase
      res_valid      = 1'b1;
      res.rtype      = 1'b1;
      res.idx        = st.param_count;
      res.tot        = st.slot_sum;
      res.ecode      = lat ? lcode : st.err_code;
      res_err_offset = lat ? loff : err_offset;
      st_next          = STATE_RESET;
      byte_offset_next = '0;
      type_start_next  = '0;
      name_start_next  = '0;
      err_offset_next  = '0;
    end else if (st.phase != PH_ERR) begin
      if (byte_offset == OffMax) begin
        lat = 1'b1; lcode = ERR_TOO_LONG; loff = OffMax;
      end else begin
        case (st.phase)
          PH_START: begin
            if (mm) begin
              if (data_byte == CH_LPAREN) wph = PH_PSTART;
              else begin
                lat = 1'b1; lcode = ERR_NO_PAREN; loff = '0;
              end
            end else begin
              wts = byte_offset; wdim = 8'd0; wph = PH_FDIMS; dims_p = 1'b1;
            end
          end
          PH_PSTART: begin
            if (data_byte == CH_RPAREN) wph = PH_RSTART;
            else begin
              wts = byte_offset; wdim = 8'd0; wph = PH_PDIMS; dims_p = 1'b1;
            end
          end
          PH_RSTART: begin
            wts = byte_offset; wdim = 8'd0; wph = PH_RDIMS; dims_p = 1'b1;
          end
          PH_PDIMS, PH_RDIMS, PH_FDIMS: dims_p = 1'b1;
          PH_PNAME, PH_RNAME, PH_FNAME: name_p = 1'b1;
          PH_DONE: begin
            lat = 1'b1; lcode = mm ? ERR_M_TRAIL : ERR_F_TRAIL; loff = byte_offset;
          end
          default: begin
            lat = 1'b1; lcode = ERR_MARKER; loff = byte_offset;
          end
        endcase

        if (dims_p) begin
          if (data_byte == CH_LBRACK) begin
            if (wdim == DIM_MAX) begin
              lat = 1'b1; lcode = ERR_DEPTH; loff = wts;
            end else begin
              wdim = wdim + 8'd1;
            end
          end else if (data_byte == CH_L) begin
            wns = byte_offset + OffsetBits'(1);
            st_next.nf_chars = 1'b0;
            st_next.nf_slash = 1'b0;
            st_next.nf_bad   = 1'b0;
            wph = (wph == PH_PDIMS) ? PH_PNAME :
                  (wph == PH_RDIMS) ? PH_RNAME : PH_FNAME;
          end else begin
            bk = base_kind(data_byte);
            if (!bk[4]) begin
              lat = 1'b1; lcode = ERR_MARKER; loff = byte_offset;
            end else if (bk[3:0] == KIND_V && (wph != PH_RDIMS || wdim != 8'd0)) begin
              lat = 1'b1; lcode = ERR_VOID; loff = wts;
            end else begin
              do_cmp = 1'b1; kind = bk[3:0];
            end
          end
        end

        if (name_p) begin
          if (data_byte == CH_SEMI) begin
            if (!st.nf_chars || st.nf_slash || st.nf_bad) begin
              lat = 1'b1; lcode = ERR_NAME; loff = name_start;
            end else begin
              do_cmp = 1'b1; kind = KIND_OBJ;
            end
          end else if (data_byte == CH_SLASH) begin
            if (!st.nf_chars || st.nf_slash) st_next.nf_bad = 1'b1;
            st_next.nf_slash = 1'b1;
            st_next.nf_chars = 1'b1;
          end else begin
            st_next.nf_slash = 1'b0;
            if (data_byte inside {CH_DOT, CH_LBRACK, CH_LPAREN, CH_RPAREN}) begin
              st_next.nf_bad = 1'b1;
            end
            st_next.nf_chars = 1'b1;
          end
        end

        if (do_cmp) begin
          if (wdim != 8'd0) slots = 2'd1;
          else if (kind == KIND_J || kind == KIND_D) slots = 2'd2;
          else if (kind == KIND_V) slots = 2'd0;
          else slots = 2'd1;
          in_res = (wph == PH_RDIMS) || (wph == PH_RNAME);
          res.kind  = kind;
          res.dims  = wdim;
          res.slots = slots;
          if (wph == PH_PDIMS || wph == PH_PNAME) begin
            sum = {1'b0, st.slot_sum} + {7'd0, slots};
            if (sum[8]) begin
              lat = 1'b1; lcode = ERR_SLOTS; loff = byte_offset + OffsetBits'(1);
            end else begin
              st_next.slot_sum    = sum[7:0];
              st_next.param_count = st.param_count + 8'd1;
              wph       = PH_PSTART;
              res_valid = 1'b1;
              res.role  = ROLE_PARAM;
              res.idx   = st.param_count;
              res.tot   = sum[7:0];
            end
          end else begin
            wph       = PH_DONE;
            res_valid = 1'b1;
            res.role  = in_res ? ROLE_RESULT : ROLE_FIELD;
            res.idx   = in_res ? st.param_count : 8'd0;
            res.tot   = st.slot_sum;
          end
        end
      end

      st_next.phase     = wph;
      st_next.dim_count = wdim;
      type_start_next   = wts;
      name_start_next   = wns;
      if (lat) begin
        st_next.phase    = PH_ERR;
        st_next.err_code = lcode;
        err_offset_next  = loff;
      end else begin
        byte_offset_next = byte_offset + OffsetBits'(1);
      end
    end
  end

endmodule

>>> src/jni_descriptor_checker_unit.sv
// An accepted request is captured in the input register, then any result in
// the result register. Throughput: one request per cycle while out_stall does
// not hold the result register (else in_stall is raised). rst is synchronous,
// active high; it returns the checker to a descriptor start, no result pending.
// Top level of the descriptor checker; depends on jdc_pkg and jdc_step.
module jni_descriptor_checker_unit #(
  parameter int OFFSET_BITS = jdc_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic        is_method,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_type,
  output logic [1:0]  type_role,
  output logic [3:0]  elem_kind,
  output logic [7:0]  array_dims,
  output logic [1:0]  type_slots,
  output logic [7:0]  param_index,
  output logic [7:0]  total_slots,
  output logic [3:0]  error_code,
  output logic [15:0] error_offset
);
  import jdc_pkg::*;

  logic                   req_valid;
  logic                   req_kind;
  logic [7:0]             req_byte;
  logic                   req_method;

  state_t                 st;
  state_t                 st_next;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic [OFFSET_BITS-1:0] type_start;
  logic [OFFSET_BITS-1:0] type_start_next;
  logic [OFFSET_BITS-1:0] name_start;
  logic [OFFSET_BITS-1:0] name_start_next;
  logic [OFFSET_BITS-1:0] err_offset;
  logic [OFFSET_BITS-1:0] err_offset_next;

  logic                   res_valid;
  result_t                res;
  logic [OFFSET_BITS-1:0] res_err_offset;

  result_t                out_res;
  logic [OFFSET_BITS-1:0] out_err_offset;

  logic                   out_free;
  logic                   fire;

  assign out_free = !out_valid || !out_stall;
  assign fire     = req_valid && out_free;
  assign in_stall = req_valid && !out_free;

  jdc_step #(
    .OffsetBits(OFFSET_BITS)
  ) u_step (
    .st               (st),
    .byte_offset      (byte_offset),
    .type_start       (type_start),
    .name_start       (name_start),
    .err_offset       (err_offset),
    .req_type         (req_kind),
    .data_byte        (req_byte),
    .is_method        (req_method),
    .st_next          (st_next),
    .byte_offset_next (byte_offset_next),
    .type_start_next  (type_start_next),
    .name_start_next  (name_start_next),
    .err_offset_next  (err_offset_next),
    .res_valid        (res_valid),
    .res              (res),
    .res_err_offset   (res_err_offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_kind   <= req_type;
      req_byte   <= data_byte;
      req_method <= is_method;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= STATE_RESET;
      byte_offset <= '0;
      type_start  <= '0;
      name_start  <= '0;
      err_offset  <= '0;
    end else if (fire) begin
      st          <= st_next;
      byte_offset <= byte_offset_next;
      type_start  <= type_start_next;
      name_start  <= name_start_next;
      err_offset  <= err_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res        <= res;
      out_err_offset <= res_err_offset;
    end
  end

  assign result_type  = out_res.rtype;
  assign type_role    = out_res.role;
  assign elem_kind    = out_res.kind;
  assign array_dims   = out_res.dims;
  assign type_slots   = out_res.slots;
  assign param_index  = out_res.idx;
  assign total_slots  = out_res.tot;
  assign error_code   = out_res.ecode;
  assign error_offset = 16'(out_err_offset);

endmodule
